// ----- rtl/spa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Shared types and function codes for the controller and the datapath.
// ----------------------------------------------------------------------------
package spa_pkg;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_LOAD_A = 2'd0;
    localparam t_func FUNC_LOAD_B = 2'd1;
    localparam t_func FUNC_ADD    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic more;
    } t_status;

endpackage

// ----- rtl/spa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module spa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder controller
// Decodes accepted transactions and sequences the merge of the two stores.
// ----------------------------------------------------------------------------
module spa_ctrl
    import spa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_func   i_func,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_func)
                        FUNC_LOAD_A: o_cmd.load_a = 1'b1;
                        FUNC_LOAD_B: o_cmd.load_b = 1'b1;
                        FUNC_ADD:    n_state = ST_MERGE;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MERGE: begin
                if (i_status.more) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == ST_IDLE))
        else $error("Controller did not return to idle after finishing a merge.");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_a || o_cmd.load_b) |-> !o_busy && !o_cmd.step && !o_cmd.finish)
        else $error("Load command issued during a merge.");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !o_cmd.step && !o_cmd.finish)
        else $error("Merge command issued while idle.");

endmodule

// ----- rtl/spa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder datapath
// Term stores, counts, merge comparator and the result register.
// ----------------------------------------------------------------------------
module spa_dp
    import spa_pkg::*;
#(
    parameter int TERM_DEPTH = 32,
    parameter int COEFF_BITS = 16,
    parameter int EXPO_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [COEFF_BITS-1:0] i_in_coeff,
    input  logic [EXPO_BITS-1:0]  i_in_expo,
    output logic                  o_strobe,
    output logic [COEFF_BITS:0]   o_out_coeff,
    output logic [EXPO_BITS-1:0]  o_out_expo,
    output logic                  o_out_valid,
    output logic                  o_out_last,
    output logic                  o_out_dropped
);

    localparam int AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
    localparam int CW = $clog2(TERM_DEPTH + 1);
    localparam int WW = COEFF_BITS + EXPO_BITS;

    logic [CW-1:0] r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [CW-1:0] r_ia, r_ib, n_ia, n_ib;
    logic          r_dropped;
    logic          full_a, full_b, we_a, we_b;
    logic [WW-1:0] wdata, rd_a, rd_b;

    logic signed [COEFF_BITS-1:0] ca, cb;
    logic [EXPO_BITS-1:0]         ea, eb;
    logic                         a_has, b_has, both, take_a, adv_a, adv_b, produce;
    logic signed [COEFF_BITS:0]   sum, new_coeff;
    logic [EXPO_BITS-1:0]         new_expo;

    logic                  r_pend_vld, n_pend_vld;
    logic [COEFF_BITS:0]   r_pend_coeff, n_pend_coeff;
    logic [EXPO_BITS-1:0]  r_pend_expo, n_pend_expo;
    logic                  r_strobe, n_strobe;
    logic [COEFF_BITS:0]   r_out_coeff, n_out_coeff;
    logic [EXPO_BITS-1:0]  r_out_expo, n_out_expo;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_last, n_out_last;
    logic                  r_out_dropped;

    assign full_a = (r_cnt_a == CW'(TERM_DEPTH));
    assign full_b = (r_cnt_b == CW'(TERM_DEPTH));
    assign we_a   = i_cmd.load_a && !full_a;
    assign we_b   = i_cmd.load_b && !full_b;
    assign wdata  = {i_in_coeff, i_in_expo};

    spa_ram #(.WIDTH(WW), .DEPTH(TERM_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_ia[AW-1:0]),
        .o_rdata (rd_a)
    );

    spa_ram #(.WIDTH(WW), .DEPTH(TERM_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_ib[AW-1:0]),
        .o_rdata (rd_b)
    );

    assign ca = $signed(rd_a[WW-1:EXPO_BITS]);
    assign cb = $signed(rd_b[WW-1:EXPO_BITS]);
    assign ea = rd_a[EXPO_BITS-1:0];
    assign eb = rd_b[EXPO_BITS-1:0];

    assign a_has   = (r_ia < r_cnt_a);
    assign b_has   = (r_ib < r_cnt_b);
    assign both    = a_has && b_has && (ea == eb);
    assign take_a  = a_has && (!b_has || (ea > eb));
    assign adv_a   = take_a || both;
    assign adv_b   = b_has && !take_a;
    assign sum     = (COEFF_BITS + 1)'(ca) + (COEFF_BITS + 1)'(cb);
    assign produce = !(both && (sum == '0));

    always_comb begin
        if (both) begin
            new_coeff = sum;
        end else if (take_a) begin
            new_coeff = (COEFF_BITS + 1)'(ca);
        end else begin
            new_coeff = (COEFF_BITS + 1)'(cb);
        end
        new_expo = take_a ? ea : eb;
    end

    assign o_status.more = a_has || b_has;

    always_comb begin
        n_ia    = r_ia;
        n_ib    = r_ib;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        if (i_cmd.finish) begin
            n_ia    = '0;
            n_ib    = '0;
            n_cnt_a = '0;
            n_cnt_b = '0;
        end else begin
            if (i_cmd.step && adv_a) begin
                n_ia = r_ia + 1'b1;
            end
            if (i_cmd.step && adv_b) begin
                n_ib = r_ib + 1'b1;
            end
            if (we_a) begin
                n_cnt_a = r_cnt_a + 1'b1;
            end
            if (we_b) begin
                n_cnt_b = r_cnt_b + 1'b1;
            end
        end
    end

    always_comb begin
        n_pend_vld   = r_pend_vld;
        n_pend_coeff = r_pend_coeff;
        n_pend_expo  = r_pend_expo;
        n_strobe     = 1'b0;
        n_out_coeff  = r_pend_coeff;
        n_out_expo   = r_pend_expo;
        n_out_valid  = 1'b1;
        n_out_last   = 1'b0;
        if (i_cmd.step && produce) begin
            n_strobe     = r_pend_vld;
            n_pend_vld   = 1'b1;
            n_pend_coeff = new_coeff;
            n_pend_expo  = new_expo;
        end else if (i_cmd.finish) begin
            n_strobe   = 1'b1;
            n_out_last = 1'b1;
            n_pend_vld = 1'b0;
            if (!r_pend_vld) begin
                n_out_coeff = '0;
                n_out_expo  = '0;
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_ia       <= '0;
            r_ib       <= '0;
            r_dropped  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_ia       <= n_ia;
            r_ib       <= n_ib;
            r_dropped  <= r_dropped || (i_cmd.load_a && full_a) || (i_cmd.load_b && full_b);
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_coeff  <= n_pend_coeff;
        r_pend_expo   <= n_pend_expo;
        r_out_coeff   <= n_out_coeff;
        r_out_expo    <= n_out_expo;
        r_out_valid   <= n_out_valid;
        r_out_last    <= n_out_last;
        r_out_dropped <= r_dropped;
    end

    assign o_strobe      = r_strobe;
    assign o_out_coeff   = r_out_coeff;
    assign o_out_expo    = r_out_expo;
    assign o_out_valid   = r_out_valid;
    assign o_out_last    = r_out_last;
    assign o_out_dropped = r_out_dropped;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ia <= r_cnt_a) && (r_ib <= r_cnt_b) && !(r_cnt_a > CW'(TERM_DEPTH))
        && !(r_cnt_b > CW'(TERM_DEPTH)))
        else $error("Read index or count out of range.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out_last) |-> (r_cnt_a == '0) && (r_cnt_b == '0) && !r_pend_vld)
        else $error("Counts or pending term not cleared after the final result.");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_out_valid) |-> r_out_last && (r_out_coeff == '0))
        else $error("Empty-result marker is malformed.");

    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_strobe && r_out_last)
        else $error("Finished merge did not produce a final result.");

endmodule

// ----- rtl/sparse_polynomial_add.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder
// A load transaction stores one term of A or B, unless that store is full. An
// add transaction keeps busy high for its merge steps plus a closing step,
// paced by the single read port of each term RAM that yields one head term
// per cycle. Each sum term is held back until the next merge step that makes
// a term, or until the closing step, so that the final one can be marked. It
// appears on o_strobe in the cycle after that step. Results come at most one
// per cycle, and the last one appears in the same cycle in which busy falls.
// They must be taken when they appear since the receiver cannot stall the
// block. The last result of an add carries o_out_last; an add with no
// surviving term yields one marker with o_out_valid low.
// ----------------------------------------------------------------------------
module sparse_polynomial_add
    import spa_pkg::*;
#(
    parameter int TERM_DEPTH = 32,
    parameter int COEFF_BITS = 16,
    parameter int EXPO_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic [COEFF_BITS-1:0] i_in_coeff,
    input  logic [EXPO_BITS-1:0]  i_in_expo,
    output logic                  o_strobe,
    output logic [COEFF_BITS:0]   o_out_coeff,
    output logic [EXPO_BITS-1:0]  o_out_expo,
    output logic                  o_out_valid,
    output logic                  o_out_last,
    output logic                  o_out_dropped
);

    t_cmd    cmd;
    t_status status;

    spa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    spa_dp #(
        .TERM_DEPTH (TERM_DEPTH),
        .COEFF_BITS (COEFF_BITS),
        .EXPO_BITS  (EXPO_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_coeff    (i_in_coeff),
        .i_in_expo     (i_in_expo),
        .o_strobe      (o_strobe),
        .o_out_coeff   (o_out_coeff),
        .o_out_expo    (o_out_expo),
        .o_out_valid   (o_out_valid),
        .o_out_last    (o_out_last),
        .o_out_dropped (o_out_dropped)
    );

endmodule

// ----- test/sparse_polynomial_add_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder checker
// Watches the command and result ports of the adder and keeps its own copy
// of both term stores, their counts and the sticky overflow flag. Each
// accepted add transaction is merged here into a queue of expected sum
// terms. Every strobed result is compared field by field with the oldest
// expected term. Mismatches and unexpected results are counted and handed
// to the testbench top together with the number of terms still due.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_checker
    import spa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_in_coeff,
    input  logic [7:0]         i_in_expo,
    input  logic               i_strobe,
    input  logic signed [16:0] i_out_coeff,
    input  logic [7:0]         i_out_expo,
    input  logic               i_out_valid,
    input  logic               i_out_last,
    input  logic               i_out_dropped,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int STORE_DEPTH = 32;

    typedef struct packed {
        logic signed [15:0] coeff;
        logic [7:0]         expo;
    } poly_term_t;

    typedef struct packed {
        logic signed [16:0] coeff;
        logic [7:0]         expo;
        logic               valid;
        logic               last;
        logic               dropped;
    } sum_term_t;

    poly_term_t  terms_a [STORE_DEPTH];
    poly_term_t  terms_b [STORE_DEPTH];
    int          n_a = 0;
    int          n_b = 0;
    bit          overflow_seen = 1'b0;
    sum_term_t   sum_q [$];
    int          fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic void push_sum(logic signed [16:0] coeff, logic [7:0] expo,
                                     logic valid);
        sum_term_t t;
        t.coeff = coeff;
        t.expo = expo;
        t.valid = valid;
        t.last = 1'b0;
        t.dropped = overflow_seen;
        sum_q.push_back(t);
    endfunction

    function automatic void merge_sums();
        int                 ia;
        int                 ib;
        int                 first;
        logic signed [16:0] s;
        sum_term_t          t;
        ia = 0;
        ib = 0;
        first = sum_q.size();
        while (ia < n_a && ib < n_b) begin
            if (terms_a[ia].expo == terms_b[ib].expo) begin
                s = terms_a[ia].coeff + terms_b[ib].coeff;
                if (s != 0) push_sum(s, terms_a[ia].expo, 1'b1);
                ia++;
                ib++;
            end else if (terms_a[ia].expo > terms_b[ib].expo) begin
                push_sum(terms_a[ia].coeff, terms_a[ia].expo, 1'b1);
                ia++;
            end else begin
                push_sum(terms_b[ib].coeff, terms_b[ib].expo, 1'b1);
                ib++;
            end
        end
        for (; ia < n_a; ia++) push_sum(terms_a[ia].coeff, terms_a[ia].expo, 1'b1);
        for (; ib < n_b; ib++) push_sum(terms_b[ib].coeff, terms_b[ib].expo, 1'b1);
        if (sum_q.size() == first) push_sum('0, '0, 1'b0);
        t = sum_q.pop_back();
        t.last = 1'b1;
        sum_q.push_back(t);
        n_a = 0;
        n_b = 0;
    endfunction

    always @(posedge i_clk) begin
        sum_term_t want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (sum_q.size() == 0) begin
                    $error("unexpected result term: coeff %0d, expo %0d",
                           i_out_coeff, i_out_expo);
                    fail_count++;
                end else begin
                    want = sum_q.pop_front();
                    if (i_out_coeff !== want.coeff) begin
                        $error("out_coeff mismatch: expected %0d, actual %0d",
                               $signed(want.coeff), i_out_coeff);
                        fail_count++;
                    end
                    if (i_out_expo !== want.expo) begin
                        $error("out_expo mismatch: expected %0d, actual %0d",
                               want.expo, i_out_expo);
                        fail_count++;
                    end
                    if (i_out_valid !== want.valid) begin
                        $error("out_valid mismatch: expected %0b, actual %0b",
                               want.valid, i_out_valid);
                        fail_count++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.last, i_out_last);
                        fail_count++;
                    end
                    if (i_out_dropped !== want.dropped) begin
                        $error("out_dropped mismatch: expected %0b, actual %0b",
                               want.dropped, i_out_dropped);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_func)
                    FUNC_LOAD_A: begin
                        if (n_a < STORE_DEPTH) begin
                            terms_a[n_a] = '{coeff: i_in_coeff, expo: i_in_expo};
                            n_a++;
                        end else begin
                            overflow_seen = 1'b1;
                        end
                    end
                    FUNC_LOAD_B: begin
                        if (n_b < STORE_DEPTH) begin
                            terms_b[n_b] = '{coeff: i_in_coeff, expo: i_in_expo};
                            n_b++;
                        end else begin
                            overflow_seen = 1'b1;
                        end
                    end
                    FUNC_ADD: begin
                        merge_sums();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending <= sum_q.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder testbench
// Drives load and add transactions into the adder: a directed opening with
// extreme terms, cancelling pairs, empty sums, unsorted loads and the unused
// function code, then random polynomial pairs in descending exponent order,
// store overflows and random noise. Random gaps, often empty, separate the
// transactions. The checker beside the adder predicts and compares results;
// this module waits for all expected terms and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    import spa_pkg::*;

    localparam t_func FUNC_UNUSED  = 2'd3;
    localparam int    IDLE_LIMIT   = 4000;
    localparam int    DRAIN_CYCLES = 80;
    localparam int    RANDOM_ITEMS = 330;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic [15:0]        i_in_coeff;
    logic [7:0]         i_in_expo;
    logic               o_strobe;
    logic signed [16:0] o_out_coeff;
    logic [7:0]         o_out_expo;
    logic               o_out_valid;
    logic               o_out_last;
    logic               o_out_dropped;
    int                 fail_count;
    int                 pending_sums;
    int                 idle_cycles = 0;
    int                 items_sent = 0;
    bit                 steady_phase = 1'b0;

    sparse_polynomial_add uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_in_coeff    (i_in_coeff),
        .i_in_expo     (i_in_expo),
        .o_strobe      (o_strobe),
        .o_out_coeff   (o_out_coeff),
        .o_out_expo    (o_out_expo),
        .o_out_valid   (o_out_valid),
        .o_out_last    (o_out_last),
        .o_out_dropped (o_out_dropped)
    );

    sparse_polynomial_add_checker sum_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_func        (i_func),
        .i_in_coeff    (i_in_coeff),
        .i_in_expo     (i_in_expo),
        .i_strobe      (o_strobe),
        .i_out_coeff   (o_out_coeff),
        .i_out_expo    (o_out_expo),
        .i_out_valid   (o_out_valid),
        .i_out_last    (o_out_last),
        .i_out_dropped (o_out_dropped),
        .o_fail_count  (fail_count),
        .o_pending     (pending_sums)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_coeff();
        case ($urandom_range(0, 15))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(1, 20));
            4: return -16'($urandom_range(1, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_func func, input logic [15:0] coeff,
                             input logic [7:0] expo);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            i_func <= 2'($urandom);
            i_in_coeff <= 16'($urandom);
            i_in_expo <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= func;
        i_in_coeff <= coeff;
        i_in_expo <= expo;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (func != FUNC_UNUSED) items_sent++;
    endtask

    task automatic send_add();
        send_item(FUNC_ADD, 16'($urandom), 8'($urandom));
    endtask

    task automatic run_poly_pair(input int pool_len);
        logic [15:0] ca [$];
        logic [15:0] cb [$];
        logic [7:0]  ea [$];
        logic [7:0]  eb [$];
        int          e;
        int          k;
        int          pick;
        int          ia;
        int          ib;
        int          max_step;
        logic [15:0] c;
        e = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
        max_step = $urandom_range(1, 12);
        for (k = 0; k < pool_len && e >= 0; k++) begin
            pick = $urandom_range(0, 2);
            c = rand_coeff();
            if (pick != 1) begin
                ca.push_back(c);
                ea.push_back(8'(e));
            end
            if (pick != 0) begin
                if (pick == 2 && $urandom_range(0, 2) == 0) cb.push_back(-c);
                else cb.push_back(rand_coeff());
                eb.push_back(8'(e));
            end
            e = e - int'($urandom_range(1, max_step));
        end
        ia = 0;
        ib = 0;
        while (ia < ca.size() || ib < cb.size()) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(FUNC_UNUSED, 16'($urandom), 8'($urandom));
            end
            if (ib >= cb.size() || (ia < ca.size() && $urandom_range(0, 1) == 1)) begin
                send_item(FUNC_LOAD_A, ca[ia], ea[ia]);
                ia++;
            end else begin
                send_item(FUNC_LOAD_B, cb[ib], eb[ib]);
                ib++;
            end
        end
        send_add();
    endtask

    task automatic run_overflow(input t_func func);
        int n;
        int k;
        n = $urandom_range(33, 36);
        for (k = 0; k < n; k++) send_item(func, rand_coeff(), 8'($urandom));
        for (k = $urandom_range(0, 3); k > 0; k--) begin
            send_item((func == FUNC_LOAD_A) ? FUNC_LOAD_B : FUNC_LOAD_A,
                      rand_coeff(), 8'($urandom));
        end
        send_add();
    endtask

    task automatic run_noise();
        int k;
        for (k = $urandom_range(1, 12); k > 0; k--) begin
            send_item(t_func'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        end
        send_add();
    endtask

    initial begin
        int seq_idx;
        int kind;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_func <= FUNC_LOAD_A;
        i_in_coeff <= '0;
        i_in_expo <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_add();
        send_item(FUNC_LOAD_A, 16'h7fff, 8'd255);
        send_item(FUNC_LOAD_A, 16'h8000, 8'd0);
        send_item(FUNC_LOAD_B, 16'h7fff, 8'd255);
        send_item(FUNC_LOAD_B, 16'h8000, 8'd0);
        send_add();
        send_item(FUNC_LOAD_A, 16'd5, 8'd10);
        send_item(FUNC_LOAD_A, 16'd0, 8'd3);
        send_item(FUNC_LOAD_B, -16'd5, 8'd10);
        send_item(FUNC_LOAD_B, 16'd7, 8'd1);
        send_add();
        send_item(FUNC_LOAD_A, 16'd9, 8'd4);
        send_item(FUNC_LOAD_B, -16'd9, 8'd4);
        send_add();
        send_item(FUNC_LOAD_A, 16'd1, 8'd2);
        send_item(FUNC_LOAD_A, 16'd3, 8'd9);
        send_item(FUNC_LOAD_B, 16'd4, 8'd5);
        send_item(FUNC_UNUSED, 16'h5a5a, 8'ha5);
        send_add();
        send_item(FUNC_LOAD_B, -16'd1, 8'd200);
        send_add();

        items_sent = 0;
        seq_idx = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 3) steady_phase = !steady_phase;
            kind = (seq_idx == 0) ? 0 : $urandom_range(0, 99);
            if (kind < 8) begin
                run_overflow(($urandom_range(0, 1) == 1) ? FUNC_LOAD_B : FUNC_LOAD_A);
            end else if (kind < 18) begin
                run_noise();
            end else if (kind < 82) begin
                run_poly_pair($urandom_range(0, 8));
            end else begin
                run_poly_pair($urandom_range(16, 30));
            end
            seq_idx++;
        end
        start <= 1'b0;

        while (pending_sums != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_sums == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
